// ----- src/ptss_pkg.sv -----
`timescale 1ns / 1ps

package ptss_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int MAX_RESULTS   = 8;
   localparam int NF_W          = $clog2(MAX_RESULTS + 1);
   localparam int TASK_W        = 8;
   localparam int PERIOD_W      = 16;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_ADD    = 2'd1,
      MODE_REMOVE = 2'd2,
      MODE_FINISH = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_FIRED = 3'd0,
      KIND_NONE  = 3'd1,
      KIND_ADDED = 3'd2,
      KIND_FULL  = 3'd3,
      KIND_DONE  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CELL_IDLE    = 2'd0,
      CELL_ADD     = 2'd1,
      CELL_FREE    = 2'd2,
      CELL_RESCHED = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic                adv;
      logic                step;
      cell_op_type         op;
      logic [TASK_W-1:0]   key_task;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] count;
   } cell_ctl_type;

   typedef struct packed {
      logic              tok;
      logic              used;
      logic              due;
      logic [TASK_W-1:0] task_id;
   } cell_stat_type;

endpackage

// ----- src/ptss_cell.sv -----
`timescale 1ns / 1ps

module ptss_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  ptss_pkg::cell_ctl_type  ctl,
   input  logic                    tok_prev,
   output ptss_pkg::cell_stat_type stat
);

   logic                          tok_ff, tok_in;
   logic                          used_ff, used_in;
   logic [ptss_pkg::TASK_W-1:0]   task_ff, task_in;
   logic [ptss_pkg::PERIOD_W-1:0] period_ff, period_in;
   logic [ptss_pkg::PERIOD_W-1:0] deadline_ff, deadline_in;
   logic                          act;

   always_comb begin
      tok_in      = ctl.adv ? tok_prev : tok_ff;
      used_in     = used_ff;
      task_in     = task_ff;
      period_in   = period_ff;
      deadline_in = deadline_ff;
      act         = tok_ff && ctl.step;
      unique case (ctl.op)
         ptss_pkg::CELL_ADD: begin
            if (act && !used_ff) begin
               used_in     = 1'b1;
               task_in     = ctl.key_task;
               period_in   = ctl.period;
               deadline_in = ctl.count + ctl.period;
            end
         end
         ptss_pkg::CELL_FREE: begin
            if (act && used_ff && task_ff == ctl.key_task) begin
               used_in = 1'b0;
            end
         end
         ptss_pkg::CELL_RESCHED: begin
            if (act && used_ff) begin
               deadline_in = ctl.count + period_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff  <= 1'b0;
         used_ff <= 1'b0;
      end else begin
         tok_ff  <= tok_in;
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      task_ff     <= task_in;
      period_ff   <= period_in;
      deadline_ff <= deadline_in;
   end

   assign stat.tok     = tok_ff;
   assign stat.used    = used_ff;
   assign stat.due     = used_ff && (deadline_ff == ctl.count);
   assign stat.task_id = task_ff;

endmodule

// ----- src/periodic_task_slot_scheduler.sv -----
`timescale 1ns / 1ps
// A token walks the slot cells, one cell per cycle unless a result stall holds the walk. Tick, add,
// remove and finish each make one walk; finish without keep on a used slot makes a second walk that
// frees the task. Each fired slot leaves when the walk reaches the next due slot, the last at the end.
// A new request is taken only after the last result of the previous one is loaded. Reset: synchronous,
// active high; all slots free, count zero.

module periodic_task_slot_scheduler #(
   parameter int SLOTS = ptss_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_task_id,
   input  logic [15:0] req_period,
   input  logic [2:0]  req_slot_index,
   input  logic        req_keep,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [2:0]  rsp_slot_number,
   output logic [7:0]  rsp_fired_task,
   output logic        rsp_last
);

   localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = (PW > 3) ? PW : 3;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SCAN2 = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   ptss_pkg::mode_type            mode_ff, mode_in;
   logic [7:0]                    id_ff, id_in;
   logic [15:0]                   period_ff, period_in;
   logic [2:0]                    idx_ff, idx_in;
   logic                          keep_ff, keep_in;
   logic [15:0]                   count_ff, count_in;
   logic [PW-1:0]                 ptr_ff, ptr_in;
   logic                          found_ff, found_in;
   logic [PW-1:0]                 found_slot_ff, found_slot_in;
   logic                          key_valid_ff, key_valid_in;
   logic [7:0]                    key_task_ff, key_task_in;
   logic                          pend_v_ff, pend_v_in;
   logic [2:0]                    pend_slot_ff, pend_slot_in;
   logic [7:0]                    pend_task_ff, pend_task_in;
   logic [ptss_pkg::NF_W-1:0]     nfound_ff, nfound_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   ptss_pkg::kind_type            rsp_kind_ff, rsp_kind_in;
   logic [2:0]                    rsp_slot_ff, rsp_slot_in;
   logic [7:0]                    rsp_task_ff, rsp_task_in;
   logic                          rsp_last_ff, rsp_last_in;

   ptss_pkg::cell_ctl_type        ctl;
   ptss_pkg::cell_stat_type       stat [SLOTS];
   ptss_pkg::cell_stat_type       sel;
   logic [SLOTS-1:0]              tok_vec;

   logic accept, out_free, step, last_cell, ptr_match, launch, key_hit, need_pass2, rsp_load;

   genvar gi;
   generate
      for (gi = 0; gi < SLOTS; gi++) begin : g_cell
         ptss_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctl      (ctl),
            .tok_prev ((gi == 0) ? launch : stat[(gi == 0) ? 0 : gi-1].tok),
            .stat     (stat[gi])
         );
         assign tok_vec[gi] = stat[gi].tok;
      end
   endgenerate

   always_comb begin
      sel = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (stat[i].tok) begin
            sel = ptss_pkg::cell_stat_type'(sel | stat[i]);
         end
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step       = ((state_ff == ST_SCAN) || (state_ff == ST_SCAN2)) && out_free;
   assign last_cell  = (ptr_ff == PW'(SLOTS - 1));
   assign ptr_match  = (CW'(ptr_ff) == CW'(idx_ff));
   assign key_hit    = step && (state_ff == ST_SCAN) && (mode_ff == ptss_pkg::MODE_FINISH)
                       && ptr_match && sel.used;
   assign need_pass2 = (mode_ff == ptss_pkg::MODE_FINISH) && !keep_ff
                       && (key_valid_ff || key_hit);
   assign launch     = accept
                       || (step && last_cell && (state_ff == ST_SCAN) && need_pass2);

   always_comb begin
      ctl.adv      = launch || step;
      ctl.step     = step;
      ctl.op       = ptss_pkg::CELL_IDLE;
      ctl.key_task = id_ff;
      ctl.period   = period_ff;
      ctl.count    = count_ff;
      if (state_ff == ST_SCAN) begin
         unique case (mode_ff)
            ptss_pkg::MODE_TICK:   ctl.op = ptss_pkg::CELL_IDLE;
            ptss_pkg::MODE_ADD:    ctl.op = found_ff ? ptss_pkg::CELL_IDLE : ptss_pkg::CELL_ADD;
            ptss_pkg::MODE_REMOVE: ctl.op = ptss_pkg::CELL_FREE;
            ptss_pkg::MODE_FINISH: begin
               ctl.op = (ptr_match && keep_ff) ? ptss_pkg::CELL_RESCHED : ptss_pkg::CELL_IDLE;
            end
            default:               ctl.op = ptss_pkg::CELL_IDLE;
         endcase
      end else if (state_ff == ST_SCAN2) begin
         ctl.op       = ptss_pkg::CELL_FREE;
         ctl.key_task = key_task_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      id_in         = id_ff;
      period_in     = period_ff;
      idx_in        = idx_ff;
      keep_in       = keep_ff;
      count_in      = count_ff;
      ptr_in        = ptr_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      key_valid_in  = key_valid_ff;
      key_task_in   = key_task_ff;
      pend_v_in     = pend_v_ff;
      pend_slot_in  = pend_slot_ff;
      pend_task_in  = pend_task_ff;
      nfound_in     = nfound_ff;
      rsp_load      = 1'b0;
      rsp_kind_in   = rsp_kind_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_last_in   = rsp_last_ff;

      if (accept) begin
         mode_in      = ptss_pkg::mode_type'(req_mode);
         id_in        = req_task_id;
         period_in    = req_period;
         idx_in       = req_slot_index;
         keep_in      = req_keep;
         ptr_in       = '0;
         found_in     = 1'b0;
         key_valid_in = 1'b0;
         pend_v_in    = 1'b0;
         nfound_in    = '0;
         state_in     = ST_SCAN;
         if (req_mode == ptss_pkg::MODE_TICK) begin
            count_in = count_ff + 16'd1;
         end
      end

      if (step) begin
         ptr_in = last_cell ? '0 : ptr_ff + PW'(1);
         if (state_ff == ST_SCAN) begin
            if (mode_ff == ptss_pkg::MODE_TICK && sel.due
                && nfound_ff < ptss_pkg::NF_W'(ptss_pkg::MAX_RESULTS)) begin
               if (pend_v_ff) begin
                  rsp_load    = 1'b1;
                  rsp_kind_in = ptss_pkg::KIND_FIRED;
                  rsp_slot_in = pend_slot_ff;
                  rsp_task_in = pend_task_ff;
                  rsp_last_in = 1'b0;
               end
               pend_v_in    = 1'b1;
               pend_slot_in = 3'(ptr_ff);
               pend_task_in = sel.task_id;
               nfound_in    = nfound_ff + ptss_pkg::NF_W'(1);
            end
            if (mode_ff == ptss_pkg::MODE_ADD && !found_ff && !sel.used) begin
               found_in      = 1'b1;
               found_slot_in = ptr_ff;
            end
            if (key_hit) begin
               key_valid_in = 1'b1;
               key_task_in  = sel.task_id;
            end
            if (last_cell) begin
               state_in = need_pass2 ? ST_SCAN2 : ST_DONE;
            end
         end else if (last_cell) begin
            state_in = ST_DONE;
         end
      end

      if (state_ff == ST_DONE && out_free) begin
         rsp_load    = 1'b1;
         rsp_last_in = 1'b1;
         rsp_slot_in = '0;
         rsp_task_in = '0;
         rsp_kind_in = ptss_pkg::KIND_DONE;
         unique case (mode_ff)
            ptss_pkg::MODE_TICK: begin
               if (pend_v_ff) begin
                  rsp_kind_in = ptss_pkg::KIND_FIRED;
                  rsp_slot_in = pend_slot_ff;
                  rsp_task_in = pend_task_ff;
               end else begin
                  rsp_kind_in = ptss_pkg::KIND_NONE;
               end
            end
            ptss_pkg::MODE_ADD: begin
               if (found_ff) begin
                  rsp_kind_in = ptss_pkg::KIND_ADDED;
                  rsp_slot_in = 3'(found_slot_ff);
                  rsp_task_in = id_ff;
               end else begin
                  rsp_kind_in = ptss_pkg::KIND_FULL;
               end
            end
            ptss_pkg::MODE_REMOVE, ptss_pkg::MODE_FINISH: rsp_kind_in = ptss_pkg::KIND_DONE;
            default: rsp_kind_in = ptss_pkg::KIND_DONE;
         endcase
         state_in = ST_IDLE;
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         found_ff     <= 1'b0;
         key_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         nfound_ff    <= '0;
         mode_ff      <= ptss_pkg::MODE_TICK;
         keep_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         found_ff     <= found_in;
         key_valid_ff <= key_valid_in;
         pend_v_ff    <= pend_v_in;
         nfound_ff    <= nfound_in;
         mode_ff      <= mode_in;
         keep_ff      <= keep_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff         <= id_in;
      period_ff     <= period_in;
      idx_ff        <= idx_in;
      found_slot_ff <= found_slot_in;
      key_task_ff   <= key_task_in;
      pend_slot_ff  <= pend_slot_in;
      pend_task_ff  <= pend_task_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_slot_number = rsp_slot_ff;
   assign rsp_fired_task  = rsp_task_ff;
   assign rsp_last        = rsp_last_ff;

   a_one_token: assert property (@(posedge clock) disable iff (reset) $onehot0(tok_vec))
      else $error("more than one token in the cell row");

   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_mode == ptss_pkg::MODE_TICK) |=> count_ff == $past(count_ff) + 16'd1)
      else $error("tick count did not advance on a tick transfer");

   a_nfound_cap: assert property (@(posedge clock) disable iff (reset)
      nfound_ff <= ptss_pkg::NF_W'(ptss_pkg::MAX_RESULTS))
      else $error("fired count above the result limit");

   a_pass2: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN2) |-> (key_valid_ff && !keep_ff && mode_ff == ptss_pkg::MODE_FINISH))
      else $error("free pass without a captured task");

endmodule
